// ----- hw/rtl/awtsw_pkg.sv -----
// ----------------------------------------------------------------------------
// awtsw_pkg
// Shared types and constants for the windowed tilt switch.
// ----------------------------------------------------------------------------
package awtsw_pkg;

  localparam int DATA_W = 10;   // sample, average and threshold width
  localparam int FILL_W = 7;    // reported fill count width

  localparam logic signed [DATA_W-1:0] TILT_THR_RESET = -10'sd90;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_INIT,
    ST_DIV,
    ST_MERGE
  } awtsw_state_t;

  // per-lane control, driven by the sequencer in the top level
  typedef struct packed {
    logic wr_en;     // write ring entry, update running sum
    logic sub_en;    // window full: remove the oldest entry from the sum
    logic clear;     // restart: zero the running sum
    logic div_init;  // load the divider from the running sum
    logic div_step;  // one restoring division step
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/awtsw_lane.sv -----
// ----------------------------------------------------------------------------
// awtsw_lane
// One axis: ring memory, running sum and a bit-serial divider.
// ----------------------------------------------------------------------------
module awtsw_lane #(
  parameter int WINDOW = 100,
  localparam int SLOT_W = $clog2(WINDOW),
  localparam int CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  awtsw_pkg::lane_ctrl_t                ctrl,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  sample,
  input  logic        [SLOT_W-1:0]             slot,
  input  logic        [CNT_W-1:0]              count,
  output logic signed [awtsw_pkg::DATA_W-1:0]  mean
);
  import awtsw_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(WINDOW);

  logic signed [DATA_W-1:0] ring_mem [WINDOW];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [SUM_W-1:0]  sum_r;
  logic        [SUM_W-1:0]  quo_r;
  logic        [CNT_W-1:0]  rem_r;
  logic                     neg_r;

  logic signed [SUM_W-1:0]  old_ext;
  logic        [CNT_W:0]    trial;
  logic                     fits;
  logic        [DATA_W-1:0] quo_lo;

  // ring: read every cycle at the current slot, write on update
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      ring_mem[slot] <= sample;
    end
    rd_q <= ring_mem[slot];
  end

  assign old_ext = ctrl.sub_en ? SUM_W'(rd_q) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      sum_r <= '0;
    end else if (ctrl.wr_en) begin
      sum_r <= sum_r - old_ext + SUM_W'(sample);
    end
  end

  // restoring divide of |sum| by the fill count, one quotient bit a cycle
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      quo_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      neg_r <= sum_r[SUM_W-1];
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign quo_lo = quo_r[DATA_W-1:0];
  assign mean   = neg_r ? -$signed(quo_lo) : $signed(quo_lo);

endmodule

// ----- hw/rtl/awtsw_merge.sv -----
// ----------------------------------------------------------------------------
// awtsw_merge
// Combine lane averages, decide the rumble toggle, hold the result word.
// ----------------------------------------------------------------------------
module awtsw_merge #(
  parameter int WINDOW = 100,
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  mean_x,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  mean_y,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  mean_z,
  input  logic        [CNT_W-1:0]              count,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  threshold,
  input  logic                                 rumble,
  output logic                                 space,
  output logic                                 toggle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_x,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_y,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_z,
  output logic        [awtsw_pkg::FILL_W-1:0]  out_fill_count,
  output logic                                 out_rumble_active,
  output logic                                 out_switched
);
  import awtsw_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

  logic full;
  logic out_valid_r;

  assign full   = (count == FULL_CNT);
  assign toggle = full && (((mean_y < threshold) && !rumble) ||
                           ((mean_y > threshold) && rumble));
  assign space  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_mean_x        <= mean_x;
      out_mean_y        <= mean_y;
      out_mean_z        <= mean_z;
      out_fill_count    <= FILL_W'(count);
      out_rumble_active <= rumble ^ toggle;
      out_switched      <= toggle;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/accel_window_average_tilt_switch_core.sv -----
// ----------------------------------------------------------------------------
// accel_window_average_tilt_switch_core
// Moving average of three-axis samples with a tilt-driven rumble switch.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample word per handshake (accel_x/y/z, signed 10 bit).
//   out_*  : one result word per sample: truncated averages over the window,
//            fill count, rumble flag after the sample and a switched marker.
//   cfg_*  : write of the signed tilt threshold; take it only while idle.
// Each axis has its own lane (ring memory, running sum, serial divider);
// the three lanes run side by side and a merge stage compares the Y average
// against the threshold and builds the result word.
// Sequence: each sample passes through idle, update, divider init, SUM_W
// divider steps, where SUM_W = 10 + clog2(WINDOW), and merge. out_valid
// rises once the merge stage loads the result, and in_ready returns
// in that same cycle. The result sits in an output register, so the next
// sample is taken while it waits; a stalled receiver only holds the block
// when a second result is ready before the first was taken.
// Reset: window empty, rumble off, threshold -90, no result pending.
// ----------------------------------------------------------------------------
module accel_window_average_tilt_switch_core #(
  parameter int WINDOW = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_x,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_y,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_x,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_y,
  output logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_z,
  output logic        [awtsw_pkg::FILL_W-1:0]  out_fill_count,
  output logic                                 out_rumble_active,
  output logic                                 out_switched,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  cfg_tilt_threshold
);
  import awtsw_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  awtsw_state_t state_r, state_nxt;
  lane_ctrl_t   lane_ctrl;

  logic signed [DATA_W-1:0] smp_x_r, smp_y_r, smp_z_r;
  logic signed [DATA_W-1:0] tilt_thr_r;
  logic        [SLOT_W-1:0] slot_r, slot_nxt;
  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic        [STEP_W-1:0] step_r, step_nxt;
  logic                     rumble_r, rumble_nxt;

  logic signed [DATA_W-1:0] mean_x, mean_y, mean_z;
  logic                     out_space;
  logic                     toggle;
  logic                     load;
  logic                     in_acc;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_thr_r <= TILT_THR_RESET;
    end else if (cfg_valid) begin
      tilt_thr_r <= cfg_tilt_threshold;
    end
  end

  // hold the accepted sample for the lanes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_x_r <= in_accel_x;
      smp_y_r <= in_accel_y;
      smp_z_r <= in_accel_z;
    end
  end

  // sequencer: update sums, run the dividers, merge, then take the next word
  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    count_nxt  = count_r;
    step_nxt   = step_r;
    rumble_nxt = rumble_r;
    lane_ctrl  = '0;
    in_ready   = 1'b0;
    load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // drop the oldest entry once the window is full, add the new one
        lane_ctrl.wr_en  = 1'b1;
        lane_ctrl.sub_en = (count_r == FULL_CNT);
        if (count_r != FULL_CNT) begin
          count_nxt = count_r + 1'b1;
        end
        slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        lane_ctrl.div_init = 1'b1;
        step_nxt           = LAST_STEP;
        state_nxt          = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_MERGE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_MERGE: begin
        // wait for room in the output register, then apply a toggle
        if (out_space) begin
          load = 1'b1;
          if (toggle) begin
            lane_ctrl.clear = 1'b1;
            rumble_nxt      = !rumble_r;
            count_nxt       = '0;
            slot_nxt        = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      slot_r   <= '0;
      count_r  <= '0;
      step_r   <= '0;
      rumble_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      count_r  <= count_nxt;
      step_r   <= step_nxt;
      rumble_r <= rumble_nxt;
    end
  end

  // one lane per axis
  awtsw_lane #(.WINDOW(WINDOW)) u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .sample (smp_x_r),
    .slot   (slot_r),
    .count  (count_r),
    .mean   (mean_x)
  );

  awtsw_lane #(.WINDOW(WINDOW)) u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .sample (smp_y_r),
    .slot   (slot_r),
    .count  (count_r),
    .mean   (mean_y)
  );

  awtsw_lane #(.WINDOW(WINDOW)) u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (lane_ctrl),
    .sample (smp_z_r),
    .slot   (slot_r),
    .count  (count_r),
    .mean   (mean_z)
  );

  awtsw_merge #(.WINDOW(WINDOW)) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .mean_x            (mean_x),
    .mean_y            (mean_y),
    .mean_z            (mean_z),
    .count             (count_r),
    .threshold         (tilt_thr_r),
    .rumble            (rumble_r),
    .space             (out_space),
    .toggle            (toggle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mean_x        (out_mean_x),
    .out_mean_y        (out_mean_y),
    .out_mean_z        (out_mean_z),
    .out_fill_count    (out_fill_count),
    .out_rumble_active (out_rumble_active),
    .out_switched      (out_switched)
  );

endmodule

// ----- hw/rtl/awtsw_checker.sv -----
// ----------------------------------------------------------------------------
// awtsw_checker
// Port-level checks for the windowed tilt switch.
// ----------------------------------------------------------------------------
module awtsw_checker #(
  parameter int WINDOW = 100
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_y,
  input logic        [awtsw_pkg::FILL_W-1:0]  out_fill_count,
  input logic                                 out_switched
);
  import awtsw_pkg::*;

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW);

  // a toggle only happens on a full window
  a_switch_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_fill_count == FULL_FILL)
    else $error("switch reported on a window that is not full");

  // one sample in flight: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is still in work");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_y))
    else $error("stalled result changed");

endmodule

bind accel_window_average_tilt_switch_core awtsw_checker #(.WINDOW(WINDOW)) u_awtsw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mean_y     (out_mean_y),
  .out_fill_count (out_fill_count),
  .out_switched   (out_switched)
);

// ----- tb/tilt_switch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_switch_checker
// Watches the sample, result and threshold channels of the tilt switch,
// predicts every result word from its own copy of the window state and
// compares it with the word the block delivers.
// ----------------------------------------------------------------------------
module tilt_switch_checker #(
  parameter int WINDOW = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_x,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_y,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  in_accel_z,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_x,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_y,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  out_mean_z,
  input  logic        [awtsw_pkg::FILL_W-1:0]  out_fill_count,
  input  logic                                 out_rumble_active,
  input  logic                                 out_switched,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic signed [awtsw_pkg::DATA_W-1:0]  cfg_tilt_threshold,
  output int                                   mismatches,
  output int                                   outstanding
);

  typedef logic signed [awtsw_pkg::DATA_W-1:0] sample_t;

  typedef struct packed {
    sample_t                      mean_x;
    sample_t                      mean_y;
    sample_t                      mean_z;
    logic [awtsw_pkg::FILL_W-1:0] fill;
    logic                         rumble;
    logic                         switched;
  } tilt_result_t;

  sample_t      hist_x [WINDOW];
  sample_t      hist_y [WINDOW];
  sample_t      hist_z [WINDOW];
  int           sum_x, sum_y, sum_z;
  int           held;
  int           slot;
  logic         rumble_state;
  int           tilt_thr;
  int           words_seen;
  tilt_result_t averages_q[$];

  // Fold one sample into the window and work out the result word it causes.
  function automatic tilt_result_t fold_sample(sample_t ax, sample_t ay, sample_t az);
    tilt_result_t r;
    int           avg_y;
    logic         flip;
    if (held >= WINDOW) begin
      sum_x -= hist_x[slot];
      sum_y -= hist_y[slot];
      sum_z -= hist_z[slot];
    end else begin
      held++;
    end
    hist_x[slot] = ax;
    hist_y[slot] = ay;
    hist_z[slot] = az;
    sum_x += ax;
    sum_y += ay;
    sum_z += az;
    slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;

    avg_y      = sum_y / held;
    r.mean_x   = sample_t'(sum_x / held);
    r.mean_y   = sample_t'(avg_y);
    r.mean_z   = sample_t'(sum_z / held);
    r.fill     = held[awtsw_pkg::FILL_W-1:0];

    // toggle only on a full window, and never on an exact match
    flip = (held >= WINDOW) &&
           ((avg_y < tilt_thr && !rumble_state) || (avg_y > tilt_thr && rumble_state));
    if (flip) begin
      rumble_state = !rumble_state;
      held         = 0;
      slot         = 0;
      sum_x        = 0;
      sum_y        = 0;
      sum_z        = 0;
    end
    r.rumble   = rumble_state;
    r.switched = flip;
    return r;
  endfunction

  always @(posedge clk) begin
    tilt_result_t got;
    tilt_result_t want;
    if (!rst_n) begin
      held         = 0;
      slot         = 0;
      sum_x        = 0;
      sum_y        = 0;
      sum_z        = 0;
      rumble_state = 1'b0;
      tilt_thr     = awtsw_pkg::TILT_THR_RESET;
      words_seen   = 0;
      mismatches   = 0;
      averages_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        tilt_thr = cfg_tilt_threshold;

      // retire before predicting, so a stray word never meets a fresh guess
      if (out_valid && out_ready) begin
        got = '{out_mean_x, out_mean_y, out_mean_z, out_fill_count,
                out_rumble_active, out_switched};
        if (averages_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result word %0d arrived with nothing expected", words_seen);
        end else begin
          want = averages_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("checker: word %0d expected x=%0d y=%0d z=%0d fill=%0d rumble=%b switched=%b",
                       words_seen, want.mean_x, want.mean_y, want.mean_z, want.fill,
                       want.rumble, want.switched);
              $display("checker: word %0d got      x=%0d y=%0d z=%0d fill=%0d rumble=%b switched=%b",
                       words_seen, got.mean_x, got.mean_y, got.mean_z, got.fill,
                       got.rumble, got.switched);
            end
          end
        end
        words_seen++;
      end

      if (in_valid && in_ready)
        averages_q.push_back(fold_sample(in_accel_x, in_accel_y, in_accel_z));
    end
    outstanding <= averages_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the windowed tilt switch.
// A short directed run of rail and sign-boundary samples is followed by
// phases of random bursts, each phase under its own tilt threshold. Bursts
// are mostly long enough to fill the window and steer the Y average below,
// above or onto the threshold, so the rumble flag really toggles; short
// bursts of noise break the sequences up. The checker beside the block does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  import awtsw_pkg::*;

  typedef logic signed [DATA_W-1:0] sample_t;

  // how the Y axis of one burst is steered relative to the threshold
  typedef enum int {
    TILT_LOW,
    TILT_HIGH,
    TILT_LEVEL,
    TILT_WIDE,
    TILT_RAIL
  } y_bias_t;

  localparam int WINDOW          = 100;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int AXIS_MAX        = 511;
  localparam int AXIS_MIN        = -512;
  localparam int DIRECTED        = 20;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 180;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 64;
  localparam int STALL_LIMIT     = 5000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  sample_t             in_accel_x, in_accel_y, in_accel_z;
  logic                out_valid;
  logic                out_ready;
  sample_t             out_mean_x, out_mean_y, out_mean_z;
  logic [FILL_W-1:0]   out_fill_count;
  logic                out_rumble_active;
  logic                out_switched;
  logic                cfg_valid;
  logic                cfg_ready;
  sample_t             cfg_tilt_threshold;

  int                  mismatches;
  int                  outstanding;
  int                  quiet_cycles;
  int                  phase_sent;
  bit                  steady;

  always #(CLK_PERIOD / 2) clk = ~clk;

  accel_window_average_tilt_switch_core #(.WINDOW(WINDOW)) DUT (.*);

  tilt_switch_checker #(.WINDOW(WINDOW)) u_checker (.*);

  // Draw an idle span: mostly none or short, now and then long; none at all
  // while a steady stretch is running.
  function automatic int idle_span();
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Saturate to the sample range.
  function automatic sample_t clip_sample(int v);
    if (v > AXIS_MAX) return sample_t'(AXIS_MAX);
    if (v < AXIS_MIN) return sample_t'(AXIS_MIN);
    return sample_t'(v);
  endfunction

  // Random value for a free axis, with the rails showing up often.
  function automatic sample_t any_axis();
    case ($urandom_range(0, 7))
      0:       return clip_sample(AXIS_MAX);
      1:       return clip_sample(AXIS_MIN);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Offer one sample word and hold it until taken, then idle for a while.
  // With no idle span, valid stays high so the next word follows directly.
  task automatic send_sample(sample_t ax, sample_t ay, sample_t az);
    int span;
    in_valid   <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    do @(posedge clk); while (!(in_valid && in_ready));
    span = idle_span();
    if (span > 0) begin
      in_valid <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  // Hold until every predicted word has come back.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the tilt threshold; call only with the block idle.
  task automatic write_threshold(int thr);
    cfg_valid          <= 1'b1;
    cfg_tilt_threshold <= sample_t'(thr);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // One burst of samples with the Y axis steered one way. Long bursts fill
  // the window so the average can cross the threshold; short ones are noise.
  task automatic run_burst(int thr);
    y_bias_t bias;
    int      len;
    int      y;
    bias = y_bias_t'($urandom_range(0, 4));
    if ($urandom_range(0, 3) == 0)
      len = $urandom_range(1, 20);
    else
      len = $urandom_range(WINDOW, WINDOW + 60);
    for (int k = 0; k < len; k++) begin
      case (bias)
        TILT_LOW:   y = thr - int'($urandom_range(1, 40));
        TILT_HIGH:  y = thr + int'($urandom_range(1, 40));
        TILT_LEVEL: y = thr;
        TILT_RAIL:  y = ($urandom_range(0, 1) != 0) ? AXIS_MAX : AXIS_MIN;
        default:    y = int'($urandom_range(0, 1023)) + AXIS_MIN;
      endcase
      send_sample(any_axis(), clip_sample(y), any_axis());
      phase_sent++;
    end
  endtask

  // Receiver: take result words with random gaps, and at the 400th word and every
  // thousandth after it hold off for a long stretch so the output register fills and in_ready drops.
  initial begin : receiver
    int taken;
    int span;
    taken = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        taken++;
        span = (taken % 1000 == 400) ? HOLD_OFF_CYCLES : idle_span();
        if (span > 0) begin
          out_ready <= 1'b0;
          repeat (span) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    // rails, sign flips around zero and odd sums that truncate toward zero
    int directed_xyz [DIRECTED][3] = '{
      '{ 511,  511,  511}, '{-512, -512, -512}, '{   0,    0,    0}, '{  -1,   -1,   -1},
      '{   1,    1,    1}, '{-512,  511,    0}, '{ 511, -512,   -1}, '{  -3,    5,   -7},
      '{   0, -512,  511}, '{  -1,    0,    1}, '{ 256, -256,  255}, '{-257,  257,   -1},
      '{ 511,  511,  511}, '{ 511,  511,  511}, '{-512, -512, -512}, '{-512, -512, -512},
      '{-512, -512, -512}, '{ -90,  -90,  -90}, '{ -91,  -89,    0}, '{   5,   -5,    5}
    };
    int phase_thr [PHASES];

    // reset value first, then both rails, zero, the reset value written
    // back, and random levels in between and at the end
    phase_thr[0] = TILT_THR_RESET;
    phase_thr[1] = AXIS_MAX;
    phase_thr[2] = AXIS_MIN;
    phase_thr[3] = int'($urandom_range(0, 1023)) + AXIS_MIN;
    phase_thr[4] = 0;
    phase_thr[5] = int'($urandom_range(0, 1023)) + AXIS_MIN;
    phase_thr[6] = TILT_THR_RESET;
    phase_thr[7] = int'($urandom_range(0, 200)) - 100;

    steady              = 1'b0;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_accel_x         <= '0;
    in_accel_y         <= '0;
    in_accel_z         <= '0;
    cfg_valid          <= 1'b0;
    cfg_tilt_threshold <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED; i++)
      send_sample(clip_sample(directed_xyz[i][0]), clip_sample(directed_xyz[i][1]),
                  clip_sample(directed_xyz[i][2]));

    for (int p = 0; p < PHASES; p++) begin
      // change the threshold only with the block empty
      if (p > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        write_threshold(phase_thr[p]);
      end
      steady     = (p == 2 || p == 5);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS)
        run_burst(phase_thr[p]);
    end

    // drain, then give the block time to show any stray word
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- accel_window_average_tilt_switch_core.f -----
hw/rtl/awtsw_pkg.sv
hw/rtl/awtsw_lane.sv
hw/rtl/awtsw_merge.sv
hw/rtl/accel_window_average_tilt_switch_core.sv
hw/rtl/awtsw_checker.sv
tb/tilt_switch_checker.sv
tb/tb.sv
